FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros: assertion helpers for the servo slew watchdog
// properties are clocked on the rising edge and off while reset is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define SVW_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("svw assertion failed");
// condition must never be seen out of reset
`define SVW_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("svw forbidden condition seen");
`else
`define SVW_ASSERT(name, clk, rstn, prop)
`define SVW_ASSERT_NEVER(name, clk, rstn, cond)
`endif
`endif

FILE: src/svw_pkg.sv
// ---------------------------------------------------------------------------
// svw_pkg: shared types and constants
// frame geometry, field widths, codes and configuration reset values
// ---------------------------------------------------------------------------
package svw_pkg;

  localparam int CHANNELS   = 18;
  localparam int FRAC_BITS  = 4;
  localparam int PULSE_W    = 16;
  localparam int PULSE_Q_W  = PULSE_W + FRAC_BITS;
  localparam int FRAME_LEN  = 2 + 2 * CHANNELS;
  localparam int FILL_W     = $clog2(FRAME_LEN + 1);
  localparam int PTR_W      = $clog2(FRAME_LEN);
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // fixed field widths
  localparam int STEP_W     = 20;
  localparam int OUT_PQ_W   = 20;
  localparam int OUT_CH_W   = 5;
  localparam int IDLE_W     = 16;
  localparam int PERIOD_W   = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 20;

  localparam logic [7:0] START_BYTE = 8'hA5;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_PULSE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // frame events
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_OK   = 2'd1;
  localparam logic [1:0] EV_BAD  = 2'd2;

  // commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIM = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WATCHDOG = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 8'd3;

  // reset values
  localparam logic [STEP_W-1:0]   RST_STEP_LIM = 20'd272;
  localparam logic [PULSE_W-1:0]  RST_MID      = 16'd1500;
  localparam logic [IDLE_W-1:0]   RST_WATCHDOG = 16'd500;
  localparam logic [PERIOD_W-1:0] RST_PERIOD   = 8'd5;

  typedef struct packed {
    logic              is_tick;
    logic              is_start;
    logic [7:0]        data;
  } item_t;

  typedef struct packed {
    logic [STEP_W-1:0]   step_lim;
    logic [PULSE_W-1:0]  mid_pulse;
    logic [IDLE_W-1:0]   watchdog;
    logic [PERIOD_W-1:0] period;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [OUT_CH_W-1:0] channel;
    logic [OUT_PQ_W-1:0] pulse_q;
    logic [1:0]          frame_event;
    logic                armed;
    logic                disable_now;
    logic                last;
  } result_t;

endpackage

FILE: src/svw_in_if.sv
// ---------------------------------------------------------------------------
// svw_in_if: request channel into the watchdog
// one received byte or one millisecond tick per request
// ---------------------------------------------------------------------------
interface svw_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink   (input valid, command, rx_byte, output ready);
endinterface

FILE: src/svw_out_if.sv
// ---------------------------------------------------------------------------
// svw_out_if: result channel out of the watchdog
// byte status, pulse updates and tick status
// ---------------------------------------------------------------------------
interface svw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  channel;
  logic [19:0] pulse_q;
  logic [1:0]  frame_event;
  logic        armed;
  logic        disable_now;
  logic        last;

  modport source (output valid, kind, channel, pulse_q, frame_event, armed,
                  disable_now, last, input ready);
  modport sink   (input valid, kind, channel, pulse_q, frame_event, armed,
                  disable_now, last, output ready);
endinterface

FILE: src/svw_cfg_if.sv
// ---------------------------------------------------------------------------
// svw_cfg_if: register write channel
// register index and write data per request
// ---------------------------------------------------------------------------
interface svw_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [19:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/svw_ram.sv
// ---------------------------------------------------------------------------
// svw_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module svw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 38
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/svw_front.sv
// ---------------------------------------------------------------------------
// svw_front: request intake
// classifies requests and holds them in a two-entry queue for the back end
// ---------------------------------------------------------------------------
module svw_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  svw_in_if.sink         in_i,
  output logic           item_valid_o,
  output svw_pkg::item_t item_o,
  input  logic           item_pop_i
);

  svw_pkg::item_t q_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  svw_pkg::item_t new_item;

  assign in_i.ready   = (count_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = q_q[rd_ptr_q];

  always_comb begin
    new_item.is_tick  = (in_i.command == svw_pkg::CMD_TICK);
    new_item.is_start = (in_i.rx_byte == svw_pkg::START_BYTE);
    new_item.data     = in_i.rx_byte;
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

FILE: src/svw_back.sv
// ---------------------------------------------------------------------------
// svw_back: frame engine, watchdog and slew sweep
// runs queued requests one at a time and drives the result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module svw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  svw_pkg::item_t item_i,
  output logic           item_pop_o,
  input  svw_pkg::cfg_t  cfg_i,
  svw_out_if.source      out_o
);

  localparam int SW = (svw_pkg::PULSE_Q_W > svw_pkg::STEP_W) ?
                      svw_pkg::PULSE_Q_W : svw_pkg::STEP_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SUM_RD  = 4'd1;
  localparam logic [3:0] S_SUM_CK  = 4'd2;
  localparam logic [3:0] S_LOAD_RD = 4'd3;
  localparam logic [3:0] S_LOAD_CK = 4'd4;
  localparam logic [3:0] S_SCAN_RD = 4'd5;
  localparam logic [3:0] S_SCAN_CK = 4'd6;
  localparam logic [3:0] S_EMIT    = 4'd7;
  localparam logic [3:0] S_SLEW    = 4'd8;

  function automatic logic [svw_pkg::PTR_W-1:0] wrap_add(
    input logic [svw_pkg::PTR_W-1:0]  base,
    input logic [svw_pkg::FILL_W-1:0] off
  );
    logic [svw_pkg::FILL_W:0] s;
    s = (svw_pkg::FILL_W+1)'(base) + (svw_pkg::FILL_W+1)'(off);
    if (s >= (svw_pkg::FILL_W+1)'(svw_pkg::FRAME_LEN)) begin
      s = s - (svw_pkg::FILL_W+1)'(svw_pkg::FRAME_LEN);
    end
    return svw_pkg::PTR_W'(s);
  endfunction

  logic [3:0]                    state_q, state_d;
  logic [svw_pkg::PTR_W-1:0]     head_q, head_d;
  logic [svw_pkg::FILL_W-1:0]    fill_q, fill_d;
  logic [svw_pkg::FILL_W-1:0]    idx_q, idx_d;
  logic [svw_pkg::CH_IDX_W-1:0]  ch_q, ch_d;
  logic [7:0]                    sum_q, sum_d;
  logic [7:0]                    chk_q, chk_d;
  logic [7:0]                    lo_q, lo_d;
  logic [1:0]                    ev_q, ev_d;
  logic                          armed_q, armed_d;
  logic [svw_pkg::IDLE_W-1:0]    idle_q, idle_d;
  logic [svw_pkg::PERIOD_W-1:0]  slew_q, slew_d;
  logic [svw_pkg::PULSE_W-1:0]   target_q [svw_pkg::CHANNELS];
  logic [svw_pkg::PULSE_Q_W-1:0] current_q [svw_pkg::CHANNELS];
  logic                          out_valid_q, out_valid_d;
  svw_pkg::result_t              res_q, res_d;

  logic                          out_free;
  logic                          we;
  logic [svw_pkg::PTR_W-1:0]     waddr, raddr;
  logic [7:0]                    rdata;
  logic [svw_pkg::FILL_W-1:0]    fill_inc;
  logic [svw_pkg::IDLE_W-1:0]    idle_inc;
  logic                          dis;
  logic                          arm_n;
  logic [svw_pkg::PERIOD_W-1:0]  st_inc, period;
  logic                          fire;
  logic                          seed_all, load_tgt, slew_wr;
  logic [SW-1:0]                 tq, cq, step, diff, cq_new;

  svw_ram #(.WIDTH(8), .DEPTH(svw_pkg::FRAME_LEN)) u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (item_i.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign waddr    = wrap_add(head_q, fill_q);
  assign fill_inc = fill_q + 1'b1;

  // watchdog and slew period for a tick
  always_comb begin
    idle_inc = (idle_q == '1) ? idle_q : idle_q + 1'b1;
    dis      = armed_q && (idle_inc > cfg_i.watchdog);
    arm_n    = armed_q && !dis;
    st_inc   = slew_q + 1'b1;
    period   = (cfg_i.period == '0) ? svw_pkg::PERIOD_W'(1) : cfg_i.period;
    fire     = arm_n && (st_inc >= period);
  end

  // one channel step toward its target
  always_comb begin
    tq   = SW'(svw_pkg::PULSE_Q_W'(target_q[ch_q]) << svw_pkg::FRAC_BITS);
    cq   = SW'(current_q[ch_q]);
    step = SW'(cfg_i.step_lim);
    if (tq > cq) begin
      diff   = tq - cq;
      cq_new = (diff > step) ? cq + step : tq;
    end else begin
      diff   = cq - tq;
      cq_new = (diff > step) ? cq - step : tq;
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    ch_d        = ch_q;
    sum_d       = sum_q;
    chk_d       = chk_q;
    lo_d        = lo_q;
    ev_d        = ev_q;
    armed_d     = armed_q;
    idle_d      = idle_q;
    slew_d      = slew_q;
    out_valid_d = out_valid_q && !out_o.ready;
    res_d       = res_q;
    item_pop_o  = 1'b0;
    we          = 1'b0;
    raddr       = head_q;
    seed_all    = 1'b0;
    load_tgt    = 1'b0;
    slew_wr     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (item_valid_i && out_free) begin
          item_pop_o = 1'b1;
          if (item_i.is_tick) begin
            idle_d  = idle_inc;
            armed_d = arm_n;
            if (arm_n) begin
              slew_d = fire ? '0 : st_inc;
            end
            if (fire) begin
              ch_d    = '0;
              state_d = S_SLEW;
            end else begin
              out_valid_d       = 1'b1;
              res_d             = '0;
              res_d.kind        = svw_pkg::KIND_TICK;
              res_d.armed       = arm_n;
              res_d.disable_now = dis;
              res_d.last        = 1'b1;
            end
          end else if (fill_q == '0 && !item_i.is_start) begin
            out_valid_d       = 1'b1;
            res_d             = '0;
            res_d.kind        = svw_pkg::KIND_BYTE;
            res_d.frame_event = svw_pkg::EV_NONE;
            res_d.armed       = armed_q;
            res_d.last        = 1'b1;
          end else begin
            we     = 1'b1;
            fill_d = fill_inc;
            if (fill_inc < svw_pkg::FILL_W'(svw_pkg::FRAME_LEN)) begin
              out_valid_d       = 1'b1;
              res_d             = '0;
              res_d.kind        = svw_pkg::KIND_BYTE;
              res_d.frame_event = svw_pkg::EV_NONE;
              res_d.armed       = armed_q;
              res_d.last        = 1'b1;
            end else begin
              chk_d   = item_i.data;
              sum_d   = '0;
              idx_d   = '0;
              state_d = S_SUM_RD;
            end
          end
        end
      end
      S_SUM_RD: begin
        raddr   = wrap_add(head_q, idx_q);
        state_d = S_SUM_CK;
      end
      S_SUM_CK: begin
        sum_d = sum_q ^ rdata;
        if (idx_q == svw_pkg::FILL_W'(svw_pkg::FRAME_LEN - 2)) begin
          if ((sum_q ^ rdata) == chk_q) begin
            if (armed_q) begin
              idx_d   = svw_pkg::FILL_W'(1);
              ch_d    = '0;
              state_d = S_LOAD_RD;
            end else begin
              seed_all = 1'b1;
              armed_d  = 1'b1;
              slew_d   = '0;
              fill_d   = '0;
              head_d   = '0;
              idle_d   = '0;
              ev_d     = svw_pkg::EV_OK;
              state_d  = S_EMIT;
            end
          end else begin
            head_d  = wrap_add(head_q, svw_pkg::FILL_W'(1));
            fill_d  = svw_pkg::FILL_W'(svw_pkg::FRAME_LEN - 1);
            ev_d    = svw_pkg::EV_BAD;
            state_d = S_SCAN_RD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SUM_RD;
        end
      end
      S_LOAD_RD: begin
        raddr   = wrap_add(head_q, idx_q);
        state_d = S_LOAD_CK;
      end
      S_LOAD_CK: begin
        if (idx_q[0]) begin
          lo_d    = rdata;
          idx_d   = idx_q + 1'b1;
          state_d = S_LOAD_RD;
        end else begin
          load_tgt = 1'b1;
          ch_d     = ch_q + 1'b1;
          idx_d    = idx_q + 1'b1;
          if (ch_q == svw_pkg::CH_IDX_W'(svw_pkg::CHANNELS - 1)) begin
            fill_d  = '0;
            head_d  = '0;
            idle_d  = '0;
            ev_d    = svw_pkg::EV_OK;
            state_d = S_EMIT;
          end else begin
            state_d = S_LOAD_RD;
          end
        end
      end
      S_SCAN_RD: begin
        raddr   = head_q;
        state_d = (fill_q == '0) ? S_EMIT : S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (rdata == svw_pkg::START_BYTE) begin
          state_d = S_EMIT;
        end else begin
          head_d  = wrap_add(head_q, svw_pkg::FILL_W'(1));
          fill_d  = fill_q - 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          res_d             = '0;
          res_d.kind        = svw_pkg::KIND_BYTE;
          res_d.frame_event = ev_q;
          res_d.armed       = armed_q;
          res_d.last        = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_SLEW: begin
        if (out_free) begin
          slew_wr       = 1'b1;
          out_valid_d   = 1'b1;
          res_d         = '0;
          res_d.kind    = svw_pkg::KIND_PULSE;
          res_d.channel = svw_pkg::OUT_CH_W'(ch_q);
          res_d.pulse_q = svw_pkg::OUT_PQ_W'(cq_new);
          res_d.armed   = armed_q;
          ch_d          = ch_q + 1'b1;
          if (ch_q == svw_pkg::CH_IDX_W'(svw_pkg::CHANNELS - 1)) begin
            res_d.last = 1'b1;
            state_d    = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      idx_q       <= '0;
      ch_q        <= '0;
      ev_q        <= svw_pkg::EV_NONE;
      armed_q     <= 1'b1;
      idle_q      <= '0;
      slew_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < svw_pkg::CHANNELS; i++) begin
        target_q[i]  <= svw_pkg::RST_MID;
        current_q[i] <= svw_pkg::PULSE_Q_W'(svw_pkg::RST_MID) << svw_pkg::FRAC_BITS;
      end
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      ch_q        <= ch_d;
      ev_q        <= ev_d;
      armed_q     <= armed_d;
      idle_q      <= idle_d;
      slew_q      <= slew_d;
      out_valid_q <= out_valid_d;
      if (seed_all) begin
        for (int i = 0; i < svw_pkg::CHANNELS; i++) begin
          target_q[i]  <= cfg_i.mid_pulse;
          current_q[i] <= svw_pkg::PULSE_Q_W'(cfg_i.mid_pulse) << svw_pkg::FRAC_BITS;
        end
      end
      if (load_tgt) begin
        target_q[ch_q] <= {rdata, lo_q};
      end
      if (slew_wr) begin
        current_q[ch_q] <= svw_pkg::PULSE_Q_W'(cq_new);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    chk_q <= chk_d;
    lo_q  <= lo_d;
    res_q <= res_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = res_q.kind;
  assign out_o.channel     = res_q.channel;
  assign out_o.pulse_q     = res_q.pulse_q;
  assign out_o.frame_event = res_q.frame_event;
  assign out_o.armed       = res_q.armed;
  assign out_o.disable_now = res_q.disable_now;
  assign out_o.last        = res_q.last;

  `SVW_ASSERT_NEVER(a_fill_range, clk_i, rst_ni, fill_q > svw_pkg::FILL_W'(svw_pkg::FRAME_LEN))
  `SVW_ASSERT_NEVER(a_head_range, clk_i, rst_ni, head_q >= svw_pkg::PTR_W'(svw_pkg::FRAME_LEN))
  `SVW_ASSERT(a_disarm_on_tick, clk_i, rst_ni,
              $fell(armed_q) |-> $past(state_q == S_IDLE && item_pop_o && item_i.is_tick))
  `SVW_ASSERT(a_slew_armed, clk_i, rst_ni, (state_q == S_SLEW) |-> armed_q)

endmodule

FILE: src/servo_frame_slew_watchdog.sv
// ---------------------------------------------------------------------------
// servo_frame_slew_watchdog: framed servo command receiver with slew limit
// frames of start byte, little-endian pulse widths and xor checksum set the
// targets; a millisecond watchdog disarms; each slew period steps all channels
// ---------------------------------------------------------------------------
//  port    | direction | carries
//  in_i    | sink      | command (byte or tick), rx_byte
//  cfg_i   | sink      | register index, write data (always ready)
//  out_o   | source    | kind, channel, pulse_q, frame_event, armed,
//          |           | disable_now, last
//
//  an ordinary byte or a plain tick is handled in the idle state alone; a
//  slew tick then steps the channels, one pulse result per cycle while
//  out_o is ready; a byte that completes a frame re-reads the buffer over
//  its single read port, a read and a check state per byte, to sum the frame
//  and, if armed, load the targets; a bad checksum starts a rescan for the
//  next start byte; a two-entry request queue decouples intake from the
//  engine; the result register stalls the engine only while out_o is not
//  ready; reset is asynchronous, active low; no clearing pass is needed
// ---------------------------------------------------------------------------
module servo_frame_slew_watchdog (
  input  logic      clk_i,
  input  logic      rst_ni,
  svw_in_if.sink    in_i,
  svw_cfg_if.sink   cfg_i,
  svw_out_if.source out_o
);

  logic           item_valid;
  svw_pkg::item_t item;
  logic           item_pop;
  svw_pkg::cfg_t  cfg_q, cfg_d;

  // register writes are always accepted
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        svw_pkg::REG_STEP_LIM: cfg_d.step_lim  = svw_pkg::STEP_W'(cfg_i.data);
        svw_pkg::REG_MID:      cfg_d.mid_pulse = svw_pkg::PULSE_W'(cfg_i.data);
        svw_pkg::REG_WATCHDOG: cfg_d.watchdog  = svw_pkg::IDLE_W'(cfg_i.data);
        svw_pkg::REG_PERIOD:   cfg_d.period    = svw_pkg::PERIOD_W'(cfg_i.data);
        default:               cfg_d = cfg_q; // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_lim  <= svw_pkg::RST_STEP_LIM;
      cfg_q.mid_pulse <= svw_pkg::RST_MID;
      cfg_q.watchdog  <= svw_pkg::RST_WATCHDOG;
      cfg_q.period    <= svw_pkg::RST_PERIOD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // intake and classification
  svw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // frame check, watchdog and slew sweep
  svw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .cfg_i        (cfg_q),
    .out_o        (out_o)
  );

endmodule
